// ----- rtl/core/cbts_pkg.sv -----
// Shared types and constants for the CAN bit timing search unit.
package cbts_pkg;

	localparam int RATE_W = 20;
	localparam int CLK_W  = 27;
	localparam int PSC_W  = 4;
	localparam int S1_W   = 5;
	localparam int S2_W   = 4;
	localparam int TOT_W  = 5;

	localparam logic [CLK_W-1:0]  CLOCK_RESET = 27'd42000000;
	localparam logic [RATE_W-1:0] HIGH_RATE   = 20'd800000;
	localparam logic [RATE_W-1:0] MID_RATE    = 20'd500000;

	typedef enum logic [1:0] {
		BAND_LOW,
		BAND_MID,
		BAND_HIGH
	} band_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	// candidate control handed from the sequencer to the judge stage
	typedef struct packed {
		logic            clear;
		logic            valid;
		band_t           band;
		logic [S1_W-1:0] s1;
		logic [S2_W-1:0] s2;
	} cand_ctl_t;

endpackage

// ----- rtl/core/cbts_judge.sv -----
// Match check, sample point check and best-candidate tracking.
module cbts_judge #(
	parameter int PSC_W  = 4,
	parameter int M_W    = 9,
	parameter int PROD_W = 29
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cbts_pkg::cand_ctl_t      ctl,
	input  logic [PSC_W-1:0]         psc,
	input  logic [M_W-1:0]           m,
	input  logic [PROD_W-1:0]        prod,
	input  logic [cbts_pkg::CLK_W-1:0] bus_clk,
	output logic                     found,
	output logic [PSC_W-1:0]         best_psc,
	output logic [cbts_pkg::S1_W-1:0] best_s1,
	output logic [cbts_pkg::S2_W-1:0] best_s2
);

	localparam int CMP_W = (PROD_W > cbts_pkg::CLK_W) ? PROD_W + 1 : cbts_pkg::CLK_W + 1;
	localparam int SP_W  = 2 * cbts_pkg::TOT_W;

	logic                      have_q;
	logic [PSC_W-1:0]          psc_q;
	logic [cbts_pkg::S1_W-1:0] s1_q;
	logic [cbts_pkg::S2_W-1:0] s2_q;
	logic [cbts_pkg::TOT_W-1:0] num_q;
	logic [cbts_pkg::TOT_W-1:0] tot_q;

	logic [CMP_W-1:0]           lo;
	logic [CMP_W-1:0]           hi;
	logic [CMP_W-1:0]           clk_x;
	logic [cbts_pkg::TOT_W-1:0] num;
	logic [cbts_pkg::TOT_W-1:0] tot;
	logic [SP_W-1:0]            lhs;
	logic [SP_W-1:0]            rhs;
	logic                       match;
	logic                       sp_ok;
	logic                       better;

	// floor(floor(clk/T)/psc) == rate  <=>  rate*T*psc <= clk < (rate+1)*T*psc
	assign lo    = CMP_W'(prod);
	assign hi    = CMP_W'(prod) + CMP_W'(m);
	assign clk_x = CMP_W'(bus_clk);
	assign match = (clk_x >= lo) && (clk_x < hi);

	assign num = cbts_pkg::TOT_W'(ctl.s1) + cbts_pkg::TOT_W'(1);
	assign tot = num + cbts_pkg::TOT_W'(ctl.s2);

	always_comb begin
		case (ctl.band)
			cbts_pkg::BAND_HIGH: sp_ok = (SP_W'(num) << 2) > (SP_W'(tot) * SP_W'(3));
			cbts_pkg::BAND_MID:  sp_ok = (SP_W'(num) * SP_W'(5)) >= (SP_W'(tot) << 2);
			default:             sp_ok = (SP_W'(num) << 3) > (SP_W'(tot) * SP_W'(7));
		endcase
	end

	// exact fraction compare; equal sample points keep the earlier candidate
	assign lhs    = SP_W'(num) * SP_W'(tot_q);
	assign rhs    = SP_W'(num_q) * SP_W'(tot);
	assign better = !have_q || (lhs > rhs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.clear) begin
			have_q <= 1'b0;
		end else if (ctl.valid && match && sp_ok && better) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			psc_q <= '0;
			s1_q  <= '0;
			s2_q  <= '0;
			num_q <= '0;
			tot_q <= cbts_pkg::TOT_W'(1);
		end else if (ctl.valid && match && sp_ok && better) begin
			psc_q <= psc;
			s1_q  <= ctl.s1;
			s2_q  <= ctl.s2;
			num_q <= num;
			tot_q <= tot;
		end
	end

	assign found    = have_q;
	assign best_psc = psc_q;
	assign best_s1  = s1_q;
	assign best_s2  = s2_q;

endmodule

// ----- rtl/core/can_bit_timing_search_unit.sv -----
// Top level: CAN bit timing search with a shared multiplier under a sequencer.
// One candidate per cycle goes through the single rate*T*psc multiplier.
// A new word is taken only when the search is idle; a result may wait in the output register.
// Reset: bus clock register loads 42 MHz, sequencer idles, output register empty.
module can_bit_timing_search_unit #(
	parameter int MAX_SEG_ONE   = 16,
	parameter int MAX_SEG_TWO   = 8,
	parameter int MAX_PRESCALER = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [cbts_pkg::CLK_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [cbts_pkg::RATE_W-1:0] bit_rate,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        found,
	output logic [cbts_pkg::PSC_W-1:0]  prescaler,
	output logic [cbts_pkg::S1_W-1:0]   segment_one,
	output logic [cbts_pkg::S2_W-1:0]   segment_two
);

	localparam int CNT_W  = $clog2(MAX_PRESCALER + 1);
	localparam int M_W    = cbts_pkg::TOT_W + CNT_W;
	localparam int PROD_W = cbts_pkg::RATE_W + M_W;

	cbts_pkg::state_t state_q, state_d;

	logic [cbts_pkg::CLK_W-1:0]  bus_clk_q;
	logic [cbts_pkg::RATE_W-1:0] rate_q;
	cbts_pkg::band_t             band_q;
	logic [cbts_pkg::S1_W-1:0]   s1_q;
	logic [cbts_pkg::S2_W-1:0]   s2_q;
	logic [CNT_W-1:0]            psc_q;
	logic [M_W-1:0]              m_q;

	cbts_pkg::cand_ctl_t         ctl_s1;
	logic [CNT_W-1:0]            psc_s1;
	logic [M_W-1:0]              m_s1;
	logic [PROD_W-1:0]           prod_s1;

	logic                        out_valid_q;
	logic                        found_q;
	logic [cbts_pkg::PSC_W-1:0]  psc_out_q;
	logic [cbts_pkg::S1_W-1:0]   s1_out_q;
	logic [cbts_pkg::S2_W-1:0]   s2_out_q;

	logic                        j_found;
	logic [CNT_W-1:0]            j_psc;
	logic [cbts_pkg::S1_W-1:0]   j_s1;
	logic [cbts_pkg::S2_W-1:0]   j_s2;

	logic                        accept;
	logic                        issue;
	logic                        last;
	logic                        psc_wrap;
	logic                        s2_wrap;
	logic                        load_out;
	logic [cbts_pkg::S1_W-1:0]   s1_n;
	logic [cbts_pkg::S2_W-1:0]   s2_n;
	logic [cbts_pkg::TOT_W-1:0]  tot_n;

	assign psc_wrap = (psc_q == CNT_W'(MAX_PRESCALER));
	assign s2_wrap  = (s2_q == cbts_pkg::S2_W'(MAX_SEG_TWO));
	assign last     = psc_wrap && s2_wrap && (s1_q == cbts_pkg::S1_W'(MAX_SEG_ONE));

	assign s1_n  = s2_wrap ? s1_q + cbts_pkg::S1_W'(1) : s1_q;
	assign s2_n  = s2_wrap ? cbts_pkg::S2_W'(1) : s2_q + cbts_pkg::S2_W'(1);
	assign tot_n = cbts_pkg::TOT_W'(1) + cbts_pkg::TOT_W'(s1_n) + cbts_pkg::TOT_W'(s2_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		accept   = 1'b0;
		issue    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			cbts_pkg::ST_IDLE: begin
				accept = in_valid;
				if (in_valid) state_d = cbts_pkg::ST_RUN;
			end
			cbts_pkg::ST_RUN: begin
				issue = 1'b1;
				if (last) state_d = cbts_pkg::ST_DRAIN;
			end
			cbts_pkg::ST_DRAIN: begin
				state_d = cbts_pkg::ST_FIN;
			end
			cbts_pkg::ST_FIN: begin
				load_out = !out_valid_q || !out_stall;
				if (load_out) state_d = cbts_pkg::ST_IDLE;
			end
			default: begin
				state_d = cbts_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != cbts_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_clk_q <= cbts_pkg::CLOCK_RESET;
		end else if (cfg_write) begin
			bus_clk_q <= cfg_data;
		end
	end

	// candidate counters: s1 outermost, prescaler innermost; m tracks T*psc
	always_ff @(posedge clk) begin
		if (accept) begin
			rate_q <= bit_rate;
			if (bit_rate > cbts_pkg::HIGH_RATE) begin
				band_q <= cbts_pkg::BAND_HIGH;
			end else if (bit_rate > cbts_pkg::MID_RATE) begin
				band_q <= cbts_pkg::BAND_MID;
			end else begin
				band_q <= cbts_pkg::BAND_LOW;
			end
			s1_q  <= cbts_pkg::S1_W'(1);
			s2_q  <= cbts_pkg::S2_W'(1);
			psc_q <= CNT_W'(1);
			m_q   <= M_W'(3);
		end else if (issue) begin
			if (psc_wrap) begin
				psc_q <= CNT_W'(1);
				s1_q  <= s1_n;
				s2_q  <= s2_n;
				m_q   <= M_W'(tot_n);
			end else begin
				psc_q <= psc_q + CNT_W'(1);
				m_q   <= m_q + M_W'(cbts_pkg::TOT_W'(1) + cbts_pkg::TOT_W'(s1_q)
					+ cbts_pkg::TOT_W'(s2_q));
			end
		end
	end

	// shared multiplier stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.clear <= accept;
			ctl_s1.valid <= issue;
			ctl_s1.band  <= band_q;
			ctl_s1.s1    <= s1_q;
			ctl_s1.s2    <= s2_q;
		end
	end

	always_ff @(posedge clk) begin
		psc_s1  <= psc_q;
		m_s1    <= m_q;
		prod_s1 <= PROD_W'(rate_q) * PROD_W'(m_q);
	end

	cbts_judge #(
		.PSC_W  (CNT_W),
		.M_W    (M_W),
		.PROD_W (PROD_W)
	) u_judge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_s1),
		.psc      (psc_s1),
		.m        (m_s1),
		.prod     (prod_s1),
		.bus_clk  (bus_clk_q),
		.found    (j_found),
		.best_psc (j_psc),
		.best_s1  (j_s1),
		.best_s2  (j_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q   <= j_found;
			psc_out_q <= cbts_pkg::PSC_W'(j_psc);
			s1_out_q  <= j_s1;
			s2_out_q  <= j_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign prescaler   = psc_out_q;
	assign segment_one = s1_out_q;
	assign segment_two = s2_out_q;

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (prescaler == '0 && segment_one == '0 && segment_two == '0))
		else $error("empty result carries nonzero fields");

	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (prescaler != '0
			&& prescaler <= cbts_pkg::PSC_W'(MAX_PRESCALER)
			&& segment_one != '0 && segment_one <= cbts_pkg::S1_W'(MAX_SEG_ONE)
			&& segment_two != '0 && segment_two <= cbts_pkg::S2_W'(MAX_SEG_TWO)))
		else $error("found result outside search range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall && ctl_s1.clear))
		else $error("search did not start after accepted word");

endmodule
